// ===== hdl/gps_imu_yaw_alignment_defines.svh =====
`ifndef GPS_IMU_YAW_ALIGNMENT_DEFINES_SVH
`define GPS_IMU_YAW_ALIGNMENT_DEFINES_SVH

// same-cycle implication
`define GYA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gya same-cycle check failed");

// next-cycle implication
`define GYA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gya next-cycle check failed");

`endif

// ===== hdl/gya_pkg.sv =====
package gya_pkg;

    localparam int CORDIC_STEPS = 28;
    localparam int STEP_W       = 5;
    localparam int CW           = 38;
    localparam int ZW           = 34;
    localparam int YAW_W        = 18;
    localparam int CFG_W        = 32;
    localparam int CFG_IDX_W    = 3;
    localparam int ROT_GAIN     = 652032874;

    localparam logic [CFG_IDX_W-1:0] CFG_YAW_OFFSET     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIFFERENCE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIFFERENCE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEED      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VARIANCE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STRAIGHT_TOL   = 3'd5;

    typedef enum logic [1:0] {
        ACT_IMU = 2'd0,
        ACT_GPS = 2'd1,
        ACT_FIX = 2'd2,
        ACT_JAM = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_VLD,
        S_VEC,
        S_HEAD,
        S_WIN,
        S_RLD,
        S_ROT,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        W_IDLE,
        W_SUM,
        W_CHK,
        W_DIV,
        W_DONE
    } t_win_state;

    typedef struct packed {
        logic wr;
        logic start;
    } t_win_ctl;

    typedef struct packed {
        logic done;
        logic pass;
    } t_win_sts;

    function automatic logic [31:0] atan_entry(input logic [STEP_W-1:0] i);
        logic [31:0] v;
        case (i)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            5'd24:   v = 32'd41;
            5'd25:   v = 32'd20;
            5'd26:   v = 32'd10;
            5'd27:   v = 32'd5;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/gya_in_if.sv =====
interface gya_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic [31:0]        variance;

    modport source (output valid, action, quat_w, quat_x, quat_y, quat_z, vel_x, vel_y,
                    variance, input ready);
    modport sink (input valid, action, quat_w, quat_x, quat_y, quat_z, vel_x, vel_y,
                  variance, output ready);
endinterface

// ===== hdl/gya_out_if.sv =====
interface gya_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] out_quat_w;
    logic signed [15:0] out_quat_z;
    logic signed [17:0] corrected_yaw;
    logic               correction_updated;

    modport source (output valid, out_quat_w, out_quat_z, corrected_yaw, correction_updated,
                    input ready);
    modport sink (input valid, out_quat_w, out_quat_z, corrected_yaw, correction_updated,
                  output ready);
endinterface

// ===== hdl/gya_cordic.sv =====
module gya_cordic import gya_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_vec,
    input  logic signed [CW-1:0] i_x,
    input  logic signed [CW-1:0] i_y,
    input  logic signed [ZW-1:0] i_z,
    output logic                 o_done,
    output logic signed [CW-1:0] o_x,
    output logic signed [CW-1:0] o_y,
    output logic signed [ZW-1:0] o_z
);

    logic                 r_run;
    logic                 r_done;
    logic [STEP_W-1:0]    r_step;
    logic                 r_vec;
    logic                 r_zero;
    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic signed [ZW-1:0] r_z;

    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [ZW-1:0] dz;
    logic                 dir;

    assign dx  = r_y >>> r_step;
    assign dy  = r_x >>> r_step;
    assign dz  = signed'({2'b00, atan_entry(r_step)});
    assign dir = r_vec ? (!r_y[CW-1] && (r_y != '0)) : r_z[ZW-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run  <= 1'b1;
                r_step <= '0;
            end else if (r_run) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(CORDIC_STEPS - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_vec  <= i_vec;
            r_zero <= i_vec && (i_x == '0) && (i_y == '0);
            if (i_vec && i_x[CW-1]) begin
                if (!i_y[CW-1]) begin
                    r_x <= i_y;
                    r_y <= -i_x;
                    r_z <= ZW'(34'h040000000);
                end else begin
                    r_x <= -i_y;
                    r_y <= i_x;
                    r_z <= ZW'(34'h0C0000000);
                end
            end else begin
                r_x <= i_x;
                r_y <= i_y;
                r_z <= i_vec ? '0 : i_z;
            end
        end else if (r_run) begin
            if (dir) begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + dz;
            end else begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - dz;
            end
        end
    end

    assign o_done = r_done;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_zero ? '0 : r_z;

endmodule

// ===== hdl/gya_window.sv =====
module gya_window import gya_pkg::*; #(
    parameter int N = 10,
    parameter int A = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_win_ctl            i_ctl,
    input  logic signed [A-1:0] i_heading,
    input  logic [14:0]         i_tol,
    output t_win_sts            o_sts,
    output logic signed [A-1:0] o_mean
);

    localparam int IW   = $clog2(N);
    localparam int CNTW = $clog2(N + 1);
    localparam int KW   = ((A > 15) ? A : 15) + $clog2(N) + 3;
    localparam int DVW  = A + $clog2(N) + 2;
    localparam int DSH  = DVW + $clog2(2 * N);
    localparam int RW   = DVW + 1;
    localparam int PW   = DVW + RW;
    localparam longint RCP = ((longint'(1) <<< DSH) + longint'(2 * N - 1)) / longint'(2 * N);
    localparam logic [RW-1:0]        RECIP = RW'(RCP);
    localparam logic signed [KW-1:0] NK    = KW'(N);

    logic signed [A-1:0] r_mem [N];
    logic [IW-1:0]       r_wpos;
    logic [CNTW-1:0]     r_cnt;
    t_win_state          r_state;
    t_win_state          n_state;
    logic [CNTW-1:0]     r_idx;
    logic signed [A-1:0] r_rd;
    logic signed [KW-1:0] r_sum;
    logic                r_fail;
    logic [DVW-1:0]      r_dvd;
    logic [A-1:0]        r_q;

    logic [IW-1:0]        rd_addr;
    logic signed [KW-1:0] hx;
    logic signed [KW-1:0] dev;
    logic signed [KW-1:0] adev;
    logic signed [KW-1:0] tol_k;
    logic signed [KW-1:0] tol_n;
    logic signed [KW-1:0] dvd_k;
    logic [PW-1:0]        qprod;
    logic                 full;
    logic                 last_idx;

    assign full     = (r_cnt == CNTW'(N));
    assign last_idx = (r_idx == CNTW'(N));
    assign rd_addr  = (r_idx < CNTW'(N)) ? r_idx[IW-1:0] : '0;
    assign hx       = KW'(r_rd);
    assign dev      = hx * NK - r_sum;
    assign adev     = dev[KW-1] ? -dev : dev;
    assign tol_k    = KW'(i_tol);
    assign tol_n    = tol_k * NK;
    assign dvd_k    = (r_sum <<< 1) + NK + (NK <<< A);
    // floor division by 2n as a reciprocal multiplication
    assign qprod    = PW'(r_dvd) * PW'(RECIP);

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[r_wpos] <= i_heading;
        end
        r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpos  <= '0;
            r_cnt   <= '0;
            r_state <= W_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            if (i_ctl.wr) begin
                r_wpos <= (r_wpos == IW'(N - 1)) ? '0 : r_wpos + 1'b1;
                if (!full) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            case (r_state)
                W_IDLE: begin
                    r_idx <= '0;
                end
                W_SUM, W_CHK: begin
                    r_idx <= last_idx ? '0 : r_idx + 1'b1;
                end
                default: begin
                    r_idx <= '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            W_IDLE: begin
                if (i_ctl.start) begin
                    r_sum  <= '0;
                    r_fail <= !full;
                end
            end
            W_SUM: begin
                if (r_idx != '0) begin
                    r_sum <= r_sum + hx;
                end
            end
            W_CHK: begin
                if ((r_idx != '0) && (adev > tol_n)) begin
                    r_fail <= 1'b1;
                end
                if (last_idx) begin
                    r_dvd <= dvd_k[DVW-1:0];
                end
            end
            W_DIV: begin
                r_q <= qprod[DSH +: A];
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            W_IDLE: begin
                if (i_ctl.start) begin
                    n_state = full ? W_SUM : W_DONE;
                end
            end
            W_SUM: begin
                if (last_idx) begin
                    n_state = W_CHK;
                end
            end
            W_CHK: begin
                if (last_idx) begin
                    n_state = W_DIV;
                end
            end
            W_DIV: begin
                n_state = W_DONE;
            end
            W_DONE: begin
                n_state = W_IDLE;
            end
            default: begin
                n_state = W_IDLE;
            end
        endcase
    end

    always_comb begin
        o_sts.done = (r_state == W_DONE);
        o_sts.pass = !r_fail;
    end

    assign o_mean = {~r_q[A-1], r_q[A-2:0]};

endmodule

// ===== hdl/gps_imu_yaw_alignment.sv =====
// Yaw alignment of an IMU orientation against GPS course over ground. Beats carry an action:
// a GPS velocity beat runs 3 multiplier steps and a 28-step CORDIC vectoring pass and yields
// no result; fix and jamming variance beats only load a variance register and the block stays
// ready. An IMU beat runs the window check only when the gates pass, and the check fails
// while the window is not yet full. The block uses one shared 17x17 multiplier, one shared
// CORDIC unit (vectoring for headings and yaw, rotation for the output half-angle sine and
// cosine, 28 iterations each), and a window walk that reads one stored heading per cycle
// and takes the mean with one reciprocal multiplication. The block takes one beat at a time;
// a finished result waits in an output register while the next beat is accepted.
// Configuration writes are taken at any time but are meant for an idle block.
module gps_imu_yaw_alignment import gya_pkg::*; #(
    parameter int WINDOW_LEN = 10,
    parameter int ANGLE_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    gya_in_if.sink               i_item,
    gya_out_if.source            o_result
);

    localparam int A = ANGLE_BITS;

    logic signed [15:0]    r_yaw_offset;
    logic [14:0]           r_min_diff;
    logic [15:0]           r_max_diff;
    logic [14:0]           r_min_speed;
    logic [31:0]           r_max_var;
    logic [14:0]           r_tol;

    t_state                r_state;
    t_state                n_state;
    t_action               r_act;
    logic signed [15:0]    r_qw;
    logic signed [15:0]    r_qx;
    logic signed [15:0]    r_qy;
    logic signed [15:0]    r_qz;
    logic signed [15:0]    r_vx;
    logic signed [15:0]    r_vy;
    logic [31:0]           r_fix;
    logic [31:0]           r_jam;
    logic signed [A-1:0]   r_last_heading;
    logic                  r_speed_ok;
    logic signed [YAW_W-1:0] r_corr;
    logic [1:0]            r_k;
    logic signed [35:0]    r_acc;
    logic signed [35:0]    r_part;
    logic signed [A-1:0]   r_yaw;
    logic                  r_upd;
    logic signed [YAW_W-1:0] r_cy;
    logic                  r_flip;

    logic                  r_ov;
    logic signed [15:0]    r_oqw;
    logic signed [15:0]    r_oqz;
    logic signed [YAW_W-1:0] r_oyaw;
    logic                  r_oupd;

    logic                  accept;
    logic                  mul_last;
    logic signed [16:0]    mul_a;
    logic signed [16:0]    mul_b;
    logic signed [33:0]    prod;
    logic                  c_start;
    logic                  c_vec;
    logic signed [CW-1:0]  c_x;
    logic signed [CW-1:0]  c_y;
    logic signed [ZW-1:0]  c_z;
    logic                  c_done;
    logic signed [CW-1:0]  c_ox;
    logic signed [CW-1:0]  c_oy;
    logic signed [ZW-1:0]  c_oz;
    logic [31:0]           zsum;
    logic signed [A-1:0]   ang;
    logic signed [31:0]    diff;
    logic [31:0]           adiff;
    logic                  gate;
    t_win_ctl              win_ctl;
    t_win_sts              win_sts;
    logic signed [A-1:0]   win_mean;
    logic signed [31:0]    corr_w;
    logic signed [31:0]    cy_w;
    logic signed [YAW_W-1:0] cy;
    logic [63:0]           hw;
    logic [31:0]           h;
    logic                  flip;
    logic signed [CW-1:0]  xf;
    logic signed [CW-1:0]  yf;
    logic signed [CW-1:0]  xr;
    logic signed [CW-1:0]  yr;
    logic signed [15:0]    qw_sat;
    logic signed [15:0]    qz_sat;
    logic                  out_free;

    assign accept   = i_item.valid && i_item.ready;
    assign out_free = !r_ov || o_result.ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_yaw_offset <= '0;
            r_min_diff   <= 15'd364;
            r_max_diff   <= 16'd16384;
            r_min_speed  <= 15'd50;
            r_max_var    <= 32'd400;
            r_tol        <= 15'd182;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_YAW_OFFSET:     r_yaw_offset <= i_cfg_data[15:0];
                CFG_MIN_DIFFERENCE: r_min_diff   <= i_cfg_data[14:0];
                CFG_MAX_DIFFERENCE: r_max_diff   <= i_cfg_data[15:0];
                CFG_MIN_SPEED:      r_min_speed  <= i_cfg_data[14:0];
                CFG_MAX_VARIANCE:   r_max_var    <= i_cfg_data[31:0];
                CFG_STRAIGHT_TOL:   r_tol        <= i_cfg_data[14:0];
                default: begin
                end
            endcase
        end
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = 17'(r_qw);
        mul_b = 17'(r_qz);
        if (r_act == ACT_GPS) begin
            case (r_k)
                2'd0: begin
                    mul_a = 17'(r_vx);
                    mul_b = 17'(r_vx);
                end
                2'd1: begin
                    mul_a = 17'(r_vy);
                    mul_b = 17'(r_vy);
                end
                default: begin
                    mul_a = signed'({2'b00, r_min_speed});
                    mul_b = signed'({2'b00, r_min_speed});
                end
            endcase
        end else begin
            case (r_k)
                2'd0: begin
                    mul_a = 17'(r_qw);
                    mul_b = 17'(r_qz);
                end
                2'd1: begin
                    mul_a = 17'(r_qx);
                    mul_b = 17'(r_qy);
                end
                2'd2: begin
                    mul_a = 17'(r_qy);
                    mul_b = 17'(r_qy);
                end
                default: begin
                    mul_a = 17'(r_qz);
                    mul_b = 17'(r_qz);
                end
            endcase
        end
    end

    assign prod     = mul_a * mul_b;
    assign mul_last = (r_act == ACT_GPS) ? (r_k == 2'd2) : (r_k == 2'd3);

    // heading from cordic angle, half-up rounding
    assign zsum = c_oz[31:0] + (32'd1 << (31 - A));
    assign ang  = zsum[31:32-A];

    assign diff  = 32'(r_last_heading) - 32'(ang);
    assign adiff = diff[31] ? 32'(-diff) : 32'(diff);
    assign gate  = (adiff > 32'(r_min_diff)) && (adiff < 32'(r_max_diff)) && r_speed_ok &&
                   (r_fix < r_max_var) && (r_jam < r_max_var);

    assign corr_w = 32'(win_mean) - 32'(r_yaw);
    assign cy_w   = 32'(r_yaw) + 32'(r_yaw_offset) + 32'(r_corr);
    assign cy     = cy_w[YAW_W-1:0];
    assign hw     = 64'(cy) << (31 - A);
    assign h      = hw[31:0];
    assign flip   = h[31] ^ h[30];

    // cordic operand select
    always_comb begin
        c_vec = (r_state == S_VLD);
        c_z   = signed'(ZW'(signed'({h[31] ^ flip, h[30:0]})));
        if (r_state == S_VLD) begin
            if (r_act == ACT_GPS) begin
                c_x = CW'(r_vx) <<< 16;
                c_y = CW'(r_vy) <<< 16;
            end else begin
                c_x = (CW'(1) <<< 30) - (CW'(r_acc) <<< 1);
                c_y = CW'(r_part) <<< 1;
            end
        end else begin
            c_x = CW'(ROT_GAIN);
            c_y = '0;
        end
    end

    // output rounding and saturation
    assign xf = r_flip ? -c_ox : c_ox;
    assign yf = r_flip ? -c_oy : c_oy;
    assign xr = (xf + (CW'(1) <<< 14)) >>> 15;
    assign yr = (yf + (CW'(1) <<< 14)) >>> 15;

    always_comb begin
        if (xr > CW'(32767)) begin
            qw_sat = 16'sd32767;
        end else if (xr < -CW'(32768)) begin
            qw_sat = -16'sd32768;
        end else begin
            qw_sat = xr[15:0];
        end
        if (yr > CW'(32767)) begin
            qz_sat = 16'sd32767;
        end else if (yr < -CW'(32768)) begin
            qz_sat = -16'sd32768;
        end else begin
            qz_sat = yr[15:0];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && !i_item.action[1]) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (mul_last) begin
                    n_state = S_VLD;
                end
            end
            S_VLD: begin
                n_state = S_VEC;
            end
            S_VEC: begin
                if (c_done) begin
                    n_state = S_HEAD;
                end
            end
            S_HEAD: begin
                if (r_act == ACT_GPS) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = gate ? S_WIN : S_RLD;
                end
            end
            S_WIN: begin
                if (win_sts.done) begin
                    n_state = S_RLD;
                end
            end
            S_RLD: begin
                n_state = S_ROT;
            end
            S_ROT: begin
                if (c_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb begin
        i_item.ready  = (r_state == S_IDLE);
        c_start       = (r_state == S_VLD) || (r_state == S_RLD);
        win_ctl.wr    = (r_state == S_HEAD) && (r_act == ACT_GPS);
        win_ctl.start = (r_state == S_HEAD) && (r_act != ACT_GPS) && gate;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_fix          <= '0;
            r_jam          <= '0;
            r_last_heading <= '0;
            r_speed_ok     <= 1'b0;
            r_corr         <= '0;
            r_ov           <= 1'b0;
            r_k            <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    r_k <= '0;
                    if (accept && (i_item.action == ACT_FIX)) begin
                        r_fix <= i_item.variance;
                    end
                    if (accept && (i_item.action == ACT_JAM)) begin
                        r_jam <= i_item.variance;
                    end
                end
                S_MUL: begin
                    r_k <= r_k + 1'b1;
                end
                S_HEAD: begin
                    if (r_act == ACT_GPS) begin
                        r_last_heading <= ang;
                        r_speed_ok     <= (r_part > r_acc);
                    end
                end
                S_WIN: begin
                    if (win_sts.done && win_sts.pass) begin
                        r_corr <= corr_w[YAW_W-1:0];
                    end
                end
                default: begin
                end
            endcase
            if ((r_state == S_DONE) && out_free) begin
                r_ov <= 1'b1;
            end else if (o_result.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_act <= t_action'(i_item.action);
                    r_qw  <= i_item.quat_w;
                    r_qx  <= i_item.quat_x;
                    r_qy  <= i_item.quat_y;
                    r_qz  <= i_item.quat_z;
                    r_vx  <= i_item.vel_x;
                    r_vy  <= i_item.vel_y;
                end
            end
            S_MUL: begin
                r_acc <= r_k[0] ? (r_acc + 36'(prod)) : 36'(prod);
                if (r_k == 2'd1) begin
                    r_part <= r_acc + 36'(prod);
                end
            end
            S_HEAD: begin
                r_yaw <= ang;
                r_upd <= 1'b0;
            end
            S_WIN: begin
                if (win_sts.done && win_sts.pass) begin
                    r_upd <= 1'b1;
                end
            end
            S_RLD: begin
                r_cy   <= cy;
                r_flip <= flip;
            end
            S_DONE: begin
                if (out_free) begin
                    r_oqw  <= qw_sat;
                    r_oqz  <= qz_sat;
                    r_oyaw <= r_cy;
                    r_oupd <= r_upd;
                end
            end
            default: begin
            end
        endcase
    end

    gya_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (c_start),
        .i_vec   (c_vec),
        .i_x     (c_x),
        .i_y     (c_y),
        .i_z     (c_z),
        .o_done  (c_done),
        .o_x     (c_ox),
        .o_y     (c_oy),
        .o_z     (c_oz)
    );

    gya_window #(
        .N (WINDOW_LEN),
        .A (ANGLE_BITS)
    ) u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (win_ctl),
        .i_heading (ang),
        .i_tol     (r_tol),
        .o_sts     (win_sts),
        .o_mean    (win_mean)
    );

    assign o_result.valid              = r_ov;
    assign o_result.out_quat_w         = r_oqw;
    assign o_result.out_quat_z         = r_oqz;
    assign o_result.corrected_yaw      = r_oyaw;
    assign o_result.correction_updated = r_oupd;

endmodule

// ===== hdl/gya_checker.sv =====
`include "gps_imu_yaw_alignment_defines.svh"

module gya_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic [1:0]  i_action,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_out_quat_w,
    input logic [15:0] i_out_quat_z,
    input logic [17:0] i_out_yaw,
    input logic        i_out_upd
);

    // variance beats never stall the input side
    `GYA_ASSERT_NEXT(a_var_ready, i_clk, i_rst_n, i_in_valid && i_in_ready && i_action[1], i_in_ready)

    // imu and gps beats occupy the block
    `GYA_ASSERT_NEXT(a_work_busy, i_clk, i_rst_n, i_in_valid && i_in_ready && !i_action[1], !i_in_ready)

    // a fresh result leaves the block free for the next beat
    `GYA_ASSERT_SAME(a_result_free, i_clk, i_rst_n, $rose(i_out_valid), i_in_ready)

    // a stalled result holds
    `GYA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_quat_w) && $stable(i_out_quat_z) && $stable(i_out_yaw) && $stable(i_out_upd))

endmodule

bind gps_imu_yaw_alignment gya_checker u_gya_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_item.valid),
    .i_in_ready   (i_item.ready),
    .i_action     (i_item.action),
    .i_out_valid  (o_result.valid),
    .i_out_ready  (o_result.ready),
    .i_out_quat_w (o_result.out_quat_w),
    .i_out_quat_z (o_result.out_quat_z),
    .i_out_yaw    (o_result.corrected_yaw),
    .i_out_upd    (o_result.correction_updated)
);
